[rtl/core/mrpm_pkg.sv]
package mrpm_pkg;

   localparam int BUF_BYTES_DEF = 4096;
   localparam int HDR_BYTES_DEF = 8;

   localparam int POS_W = 12;
   localparam int LEN_W = 13;
   localparam int OP_W  = 2;

   localparam logic [LEN_W-1:0] RING_SIZE_RST = 13'd4096;

   localparam logic [OP_W-1:0] OP_RESERVE = 2'd0;
   localparam logic [OP_W-1:0] OP_COMMIT  = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

   localparam logic KIND_SKIP    = 1'b0;
   localparam logic KIND_PACKAGE = 1'b1;

   typedef struct packed {
      logic [POS_W-1:0] payload_offset;
      logic [POS_W-1:0] amount;
   } res_type;

   typedef struct packed {
      logic             kind_we;
      logic             len_we;
      logic [POS_W-1:0] wpos;
      logic             wkind;
      logic [LEN_W-1:0] wlen;
      logic [POS_W-1:0] rpos;
   } mem_req_type;

   typedef struct packed {
      logic             kind;
      logic [LEN_W-1:0] len;
   } mem_rsp_type;

   // The offset is cleared only when the full amount is zero, before it is cut
   // to the width of the result.
   function automatic res_type make_res(input logic [POS_W-1:0] off,
                                        input logic [LEN_W+1:0] amt);
      res_type r;
      r.amount         = amt[POS_W-1:0];
      r.payload_offset = (amt == '0) ? '0 : off;
      return r;
   endfunction

endpackage

[rtl/core/mrpm_ram.sv]
module mrpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mrpm_seq.sv]
module mrpm_seq #(
   parameter int HDR_BYTES = mrpm_pkg::HDR_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mrpm_pkg::OP_W-1:0]   req_op,
   input  logic [mrpm_pkg::LEN_W-1:0]  req_length,
   input  logic [mrpm_pkg::LEN_W-1:0]  ring_size,
   output logic                        res_valid,
   input  logic                        res_ready,
   output mrpm_pkg::res_type           res,
   output mrpm_pkg::mem_req_type       mem_req,
   input  mrpm_pkg::mem_rsp_type       mem_rsp
);
   import mrpm_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_RETRY, ST_HOLD} state_type;

   localparam logic [14:0]      Hdr15 = 15'(HDR_BYTES);
   localparam logic [POS_W-1:0] Hdr12 = POS_W'(HDR_BYTES);

   state_type        state_ff, state_in;
   logic [POS_W-1:0] head_ff, head_in;
   logic [POS_W-1:0] tail_ff, tail_in;
   res_type          hold_ff, hold_in;

   logic        accept;
   logic [14:0] rs15, h15, t15, len15, need15;
   logic [14:0] room_a, room_b, rel_next;
   logic        low_side, fit_a, fit_b, hdr_ok_a;
   logic [POS_W-1:0] t_b;
   logic [14:0] avail_c, cap_c, avail_l, cap_l, mlen15;
   logic        ok_c, ok_l;
   logic        res_valid_c;
   res_type     res_c;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE);

   assign rs15     = {2'b0, ring_size};
   assign h15      = {3'b0, head_ff};
   assign t15      = {3'b0, tail_ff};
   assign len15    = {2'b0, req_length};
   assign need15   = Hdr15 + len15;
   assign low_side = (head_ff <= tail_ff);
   assign room_a   = rs15 - t15 - 15'd1;
   assign fit_a    = $signed(room_a) >= $signed(need15);
   assign hdr_ok_a = $signed(room_a) >= $signed(Hdr15);
   assign t_b      = low_side ? '0 : tail_ff;
   assign room_b   = h15 - {3'b0, t_b} - 15'd1;
   assign fit_b    = $signed(room_b) >= $signed(need15);
   assign rel_next = h15 + Hdr15 + len15;

   assign mlen15  = {2'b0, mem_rsp.len};
   assign avail_c = rs15 - h15 - 15'd1;
   assign ok_c    = ($signed(avail_c) >= $signed(Hdr15)) && (mem_rsp.kind == KIND_PACKAGE);
   assign cap_c   = avail_c - Hdr15;
   assign avail_l = t15 - h15;
   assign ok_l    = avail_l >= Hdr15;
   assign cap_l   = avail_l - Hdr15;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      hold_in     = hold_ff;
      res_valid_c = 1'b0;
      res_c       = make_res('0, '0);
      mem_req     = '0;
      mem_req.rpos = (state_ff == ST_READ) ? '0 : head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_valid_c = 1'b1;
               unique case (req_op)
                  OP_RESERVE: begin
                     if (low_side && fit_a) begin
                        res_c = make_res(tail_ff + Hdr12, room_a - Hdr15);
                     end else begin
                        if (low_side && hdr_ok_a) begin
                           mem_req.kind_we = 1'b1;
                           mem_req.wpos    = tail_ff;
                           mem_req.wkind   = KIND_SKIP;
                        end
                        if (!(low_side && head_ff == '0)) begin
                           tail_in = t_b;
                           if (fit_b) begin
                              res_c = make_res(t_b + Hdr12, room_b - Hdr15);
                           end
                        end
                     end
                  end
                  OP_COMMIT: begin
                     if (req_length != '0) begin
                        mem_req.kind_we = 1'b1;
                        mem_req.len_we  = 1'b1;
                        mem_req.wpos    = tail_ff;
                        mem_req.wkind   = KIND_PACKAGE;
                        mem_req.wlen    = req_length;
                        tail_in = tail_ff + Hdr12 + req_length[POS_W-1:0];
                     end
                  end
                  OP_PEEK: begin
                     res_valid_c = 1'b0;
                     state_in    = ST_READ;
                  end
                  OP_RELEASE: begin
                     head_in = (rel_next >= rs15) ? '0 : rel_next[POS_W-1:0];
                  end
                  default: begin
                     res_valid_c = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (low_side) begin
               res_valid_c = 1'b1;
               if (ok_l) begin
                  res_c = make_res(head_ff + Hdr12, (cap_l < mlen15) ? cap_l : mlen15);
               end
            end else if (ok_c) begin
               res_valid_c = 1'b1;
               res_c = make_res(head_ff + Hdr12, (cap_c < mlen15) ? cap_c : mlen15);
            end else begin
               head_in  = '0;
               state_in = ST_RETRY;
            end
         end
         ST_RETRY: begin
            res_valid_c = 1'b1;
            if (ok_l) begin
               res_c = make_res(head_ff + Hdr12, (cap_l < mlen15) ? cap_l : mlen15);
            end
         end
         ST_HOLD: begin
            res_valid_c = 1'b1;
            res_c       = hold_ff;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (res_valid_c && state_ff != ST_HOLD) begin
         if (res_ready) begin
            state_in = ST_IDLE;
         end else begin
            hold_in  = res_c;
            state_in = ST_HOLD;
         end
      end
   end

   assign res_valid = res_valid_c;
   assign res       = res_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
      hold_ff <= hold_in;
   end

   a_read_after_peek: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> $past(req_valid && req_ready && req_op == OP_PEEK))
      else $error("Header read state entered without a peek item.");

   a_retry_from_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RETRY |-> head_ff == '0 && $past(state_ff == ST_READ))
      else $error("Peek retry does not start at offset zero.");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      (mem_req.kind_we || mem_req.len_we) |-> state_ff == ST_IDLE && accept)
      else $error("Header write outside an accepted item.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> state_ff == ST_HOLD && hold_ff == $past(res))
      else $error("Stalled result was not held.");

endmodule

[rtl/core/message_ring_pointer_manager_core.sv]
// Pointer manager for a single-producer, single-consumer ring of variable-length
// messages. Each item on the req_ channel carries an operation (reserve, commit,
// peek, release) and a byte length; each item yields exactly one rsp_ item with
// a payload offset and an amount, which are zero for commit and release.
// The csr_ channel writes the usable ring size and is always ready; it should
// be written only while no item is in flight.
// Reserve, commit and release finish in the cycle they are accepted, and their
// result is registered on rsp_, so they sustain one item per cycle while the
// receiver does not stall. Peek reads the header at the head from the header
// memory, whose read output is registered, and registers its result on rsp_;
// when the head has to wrap to offset zero, it reads a second header first.
// A new item is accepted only once the previous one has produced its result.
// While the receiver stalls, the output register holds one result and one
// more result is held inside, after which req_ready drops.
// Reset clears the pointers and sets the ring size to 4096 bytes. The header
// memories are not cleared.
module message_ring_pointer_manager_core #(
   parameter int BUF_BYTES = mrpm_pkg::BUF_BYTES_DEF,
   parameter int HDR_BYTES = mrpm_pkg::HDR_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [mrpm_pkg::OP_W-1:0]  req_op,
   input  logic [mrpm_pkg::LEN_W-1:0] req_length,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [mrpm_pkg::POS_W-1:0] rsp_payload_offset,
   output logic [mrpm_pkg::POS_W-1:0] rsp_amount,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [mrpm_pkg::LEN_W-1:0] csr_ring_size
);
   import mrpm_pkg::*;

   localparam int AW = $clog2(BUF_BYTES);

   logic [LEN_W-1:0] ring_size_ff;
   logic             rsp_valid_ff;
   logic [POS_W-1:0] rsp_off_ff;
   logic [POS_W-1:0] rsp_amt_ff;
   logic             rd_ok_ff;

   logic        res_valid, res_ready;
   res_type     res;
   mem_req_type mem_req;
   mem_rsp_type mem_rsp;

   logic            wr_ok, rd_ok;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic            kind_q;
   logic [LEN_W-1:0] len_q;

   assign csr_ready = 1'b1;
   assign res_ready = !rsp_valid_ff || rsp_ready;

   assign wr_ok   = 32'(mem_req.wpos) < 32'(BUF_BYTES);
   assign rd_ok   = 32'(mem_req.rpos) < 32'(BUF_BYTES);
   assign wr_addr = AW'(mem_req.wpos);
   assign rd_addr = AW'(mem_req.rpos);

   assign mem_rsp.kind = rd_ok_ff & kind_q;
   assign mem_rsp.len  = rd_ok_ff ? len_q : '0;

   mrpm_seq #(
      .HDR_BYTES (HDR_BYTES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_length (req_length),
      .ring_size  (ring_size_ff),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .mem_req    (mem_req),
      .mem_rsp    (mem_rsp)
   );

   mrpm_ram #(
      .WIDTH (1),
      .DEPTH (BUF_BYTES)
   ) u_kind_ram (
      .clock   (clock),
      .wr_en   (mem_req.kind_we && wr_ok),
      .wr_addr (wr_addr),
      .wr_data (mem_req.wkind),
      .rd_addr (rd_addr),
      .rd_data (kind_q)
   );

   mrpm_ram #(
      .WIDTH (LEN_W),
      .DEPTH (BUF_BYTES)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (mem_req.len_we && wr_ok),
      .wr_addr (wr_addr),
      .wr_data (mem_req.wlen),
      .rd_addr (rd_addr),
      .rd_data (len_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= RING_SIZE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            ring_size_ff <= csr_ring_size;
         end
         if (res_valid && res_ready) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (res_valid && res_ready) begin
         rsp_off_ff <= res.payload_offset;
         rsp_amt_ff <= res.amount;
      end
      rd_ok_ff <= rd_ok;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_offset = rsp_off_ff;
   assign rsp_amount         = rsp_amt_ff;

endmodule
